// File: src/pbpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbpc_pkg
// Shared constants, types and tables of the proportional band PWM controller.
// ----------------------------------------------------------------------------
package pbpc_pkg;

	localparam int PWM_STEPS  = 20;
	localparam int TICK_W     = $clog2(PWM_STEPS);
	localparam int ON_W       = $clog2(PWM_STEPS + 1);

	localparam int SAMPLE_W   = 10;
	localparam int REG_W      = 7;
	localparam int ERR_W      = 8;
	localparam int PV_W       = 7;
	localparam int TENTHS_W   = 4;
	localparam int DRIVE_W    = 7;

	localparam int DIV_W      = 12;
	localparam int DIVISOR_W  = 7;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam int Q_MAX      = 20;
	localparam int Q_W        = 5;
	localparam int DRIVE_STEP = 100 / Q_MAX;
	localparam int DECIMAL    = 10;
	localparam int MIN_BAND   = 2;

	localparam logic [REG_W-1:0] SETPOINT_RST = REG_W'(40);
	localparam logic [REG_W-1:0] BAND_RST     = REG_W'(40);

	typedef enum logic [0:0] {
		REG_SETPOINT = 1'b0,
		REG_BAND     = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quotient;
		logic [DIVISOR_W-1:0] remainder;
	} div_rsp_t;

	typedef logic [ON_W-1:0] on_tbl_t [0:(2**Q_W)-1];

	function automatic on_tbl_t build_on_tbl();
		on_tbl_t t;
		for (int i = 0; i < 2**Q_W; i++) begin
			t[i] = ON_W'((i * PWM_STEPS) / Q_MAX);
		end
		return t;
	endfunction

	localparam on_tbl_t ON_TBL = build_on_tbl();

endpackage
`default_nettype wire

// File: src/pbpc_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbpc_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbpc_sdiv (
	input  wire               clk,
	input  wire               arst_n,
	input  pbpc_pkg::div_req_t req,
	output pbpc_pkg::div_rsp_t rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [pbpc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [pbpc_pkg::DIV_W-1:0]         quo_q;
	logic [pbpc_pkg::DIVISOR_W-1:0]     rem_q;
	logic [pbpc_pkg::DIVISOR_W-1:0]     dsr_q;

	logic [pbpc_pkg::DIVISOR_W:0]       trial;
	logic                               fits;
	logic [pbpc_pkg::DIVISOR_W:0]       diff;

	assign trial = {rem_q, quo_q[pbpc_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pbpc_pkg::DIV_CNT_W'(pbpc_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pbpc_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? diff[pbpc_pkg::DIVISOR_W-1:0] : trial[pbpc_pkg::DIVISOR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

// File: src/proportional_band_pwm_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_band_pwm_controller_top
// Proportional band controller with a time-proportioned output.
// ----------------------------------------------------------------------------
// One item is one control-period tick carrying a converter sample. The block
// splits the sample into whole and tenths by ten, forms the error against the
// setpoint, maps it across the proportional band to a drive in steps of five
// percent, and gates the output against a wrapping tick counter. One shared
// bit-serial divider does both divisions, each loaded by a registered start
// request; the second is skipped when the error lies outside the band. When
// the result is loaded the block returns to idle, ready for the next item.
// A new item is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module proportional_band_pwm_controller_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire                              cfg_index,
	input  wire [pbpc_pkg::REG_W-1:0]        cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [pbpc_pkg::SAMPLE_W-1:0]     adc_sample,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [pbpc_pkg::DRIVE_W-1:0]     drive_percent,
	output logic                             output_active,
	output logic signed [pbpc_pkg::ERR_W-1:0] control_error,
	output logic [pbpc_pkg::PV_W-1:0]        pv_whole,
	output logic [pbpc_pkg::TENTHS_W-1:0]    pv_tenths
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_ERR,
		ST_DIV2,
		ST_FIN
	} state_t;

	state_t                              state_q;
	logic [pbpc_pkg::REG_W-1:0]          setpoint_q;
	logic [pbpc_pkg::REG_W-1:0]          band_q;
	logic [pbpc_pkg::TICK_W-1:0]         tick_q;
	pbpc_pkg::div_req_t                  req_q;
	pbpc_pkg::div_rsp_t                  rsp;
	logic [pbpc_pkg::PV_W-1:0]           whole_q;
	logic [pbpc_pkg::TENTHS_W-1:0]       tenths_q;
	logic signed [pbpc_pkg::ERR_W-1:0]   err_q;
	logic [pbpc_pkg::Q_W-1:0]            q_q;

	logic                                out_valid_q;
	logic [pbpc_pkg::DRIVE_W-1:0]        drive_q;
	logic                                active_q;
	logic signed [pbpc_pkg::ERR_W-1:0]   error_q;
	logic [pbpc_pkg::PV_W-1:0]           pv_whole_q;
	logic [pbpc_pkg::TENTHS_W-1:0]       pv_tenths_q;

	logic [pbpc_pkg::REG_W-1:0]          band_eff;
	logic signed [pbpc_pkg::ERR_W-1:0]   half_s;
	logic                                below;
	logic                                above;
	logic [pbpc_pkg::ERR_W-1:0]          num;
	logic [pbpc_pkg::DIV_W-1:0]          scaled;
	logic [pbpc_pkg::ON_W-1:0]           on_ticks;
	logic                                load_out;

	pbpc_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign band_eff = (band_q < pbpc_pkg::REG_W'(pbpc_pkg::MIN_BAND))
		? pbpc_pkg::REG_W'(pbpc_pkg::MIN_BAND) : band_q;
	assign half_s   = signed'({2'b00, band_eff[pbpc_pkg::REG_W-1:1]});
	assign below    = err_q < -half_s;
	assign above    = err_q > half_s;
	assign num      = pbpc_pkg::ERR_W'(err_q + half_s);
	assign scaled   = pbpc_pkg::DIV_W'({num, 4'b0000}) + pbpc_pkg::DIV_W'({num, 2'b00});
	assign on_ticks = pbpc_pkg::ON_TBL[q_q];
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= pbpc_pkg::SETPOINT_RST;
			band_q     <= pbpc_pkg::BAND_RST;
		end else if (cfg_we) begin
			unique case (pbpc_pkg::reg_index_t'(cfg_index))
				pbpc_pkg::REG_SETPOINT: setpoint_q <= cfg_data;
				pbpc_pkg::REG_BAND:     band_q     <= cfg_data;
				default:                ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			out_valid_q <= 1'b0;
			tick_q      <= '0;
			whole_q     <= '0;
			tenths_q    <= '0;
			err_q       <= '0;
			q_q         <= '0;
			drive_q     <= '0;
			active_q    <= 1'b0;
			error_q     <= '0;
			pv_whole_q  <= '0;
			pv_tenths_q <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q.start    <= 1'b1;
						req_q.dividend <= pbpc_pkg::DIV_W'(adc_sample);
						req_q.divisor  <= pbpc_pkg::DIVISOR_W'(pbpc_pkg::DECIMAL);
						state_q        <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (rsp.done) begin
						whole_q  <= rsp.quotient[pbpc_pkg::PV_W-1:0];
						tenths_q <= rsp.remainder[pbpc_pkg::TENTHS_W-1:0];
						err_q    <= signed'({1'b0, setpoint_q})
							- signed'({1'b0, rsp.quotient[pbpc_pkg::PV_W-1:0]});
						state_q  <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (below) begin
						q_q     <= '0;
						state_q <= ST_FIN;
					end else if (above) begin
						q_q     <= pbpc_pkg::Q_W'(pbpc_pkg::Q_MAX);
						state_q <= ST_FIN;
					end else begin
						req_q.start    <= 1'b1;
						req_q.dividend <= scaled;
						req_q.divisor  <= band_eff;
						state_q        <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (rsp.done) begin
						q_q     <= rsp.quotient[pbpc_pkg::Q_W-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						drive_q     <= pbpc_pkg::DRIVE_W'(q_q * pbpc_pkg::DRIVE_STEP);
						active_q    <= pbpc_pkg::ON_W'(tick_q) < on_ticks;
						error_q     <= err_q;
						pv_whole_q  <= whole_q;
						pv_tenths_q <= tenths_q;
						tick_q      <= (tick_q == pbpc_pkg::TICK_W'(pbpc_pkg::PWM_STEPS - 1))
							? '0 : tick_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_percent = drive_q;
	assign output_active = active_q;
	assign control_error = error_q;
	assign pv_whole      = pv_whole_q;
	assign pv_tenths     = pv_tenths_q;

`ifndef SYNTHESIS
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_percent <= pbpc_pkg::DRIVE_W'(100)) && (pv_tenths <= 4'd9))
		else $error("drive or tenths out of range");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= pbpc_pkg::TICK_W'(pbpc_pkg::PWM_STEPS - 1))
		else $error("tick counter out of range");

	a_active_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && output_active) |-> (drive_percent != '0))
		else $error("output active with zero drive");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_q.start |=> !req_q.start)
		else $error("divider started twice in a row");
`endif

endmodule
`default_nettype wire
